// ===== hw/rtl/okvt_pkg.sv =====
package okvt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream payloads.
    localparam int CMD_BITS       = 3;
    localparam int KEY_FIELD_BITS = 32;
    localparam int VAL_FIELD_BITS = 32;
    localparam int POS_BITS       = 4;
    localparam int CNT_FIELD_BITS = 5;
    localparam int S_TDATA_BITS   = 72;
    localparam int M_TDATA_BITS   = 72;

    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [POS_BITS-1:0]   pos_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT         = 3'd0,
        CMD_UPDATE         = 3'd1,
        CMD_INSERT_UPDATE  = 3'd2,
        CMD_ERASE          = 3'd3,
        CMD_CONTAINS       = 3'd4,
        CMD_GET_BY_KEY     = 3'd5,
        CMD_GET_BY_POS     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMP  = 2'd1,
        ST_ACT  = 2'd2
    } state_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;     // compare the request key and latch the match flag
        logic upd;     // matching cell takes the request value
        logic app;     // cell at the count position takes the request entry
        logic shift;   // cells at or above the match take the upper neighbor
    } cell_ctrl_t;

    typedef struct packed {
        cmd_t   cmd;
        key_t   key;
        value_t value;
        pos_t   position;
    } req_t;

    typedef struct packed {
        logic   ok;
        logic   full_res;
        key_t   key_out;
        value_t value_out;
        count_t count;
    } res_t;

endpackage

// ===== hw/rtl/okvt_cell.sv =====
module okvt_cell (
    input  logic                 aclk,
    input  okvt_pkg::cell_ctrl_t ctrl,
    input  okvt_pkg::idx_t       cell_idx,
    input  okvt_pkg::count_t     count,
    input  okvt_pkg::key_t       req_key,
    input  okvt_pkg::value_t     req_value,
    input  okvt_pkg::key_t       up_key,
    input  okvt_pkg::value_t     up_value,
    input  logic                 chain_in,
    output logic                 chain_out,
    output okvt_pkg::key_t       key,
    output okvt_pkg::value_t     value,
    output logic                 match
);
    import okvt_pkg::*;

    key_t   key_reg, key_next;
    value_t value_reg, value_next;
    logic   match_reg, match_next;
    logic   valid;
    logic   append_here;

    assign valid       = COUNT_BITS'(cell_idx) < count;
    assign append_here = COUNT_BITS'(cell_idx) == count;

    // The erase chain is high from the matching cell upward.
    assign chain_out = chain_in | match_reg;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        match_next = match_reg;
        if (ctrl.cmp) begin
            match_next = valid && (key_reg == req_key);
        end
        priority if (ctrl.shift && chain_out) begin
            key_next   = up_key;
            value_next = up_value;
        end else if (ctrl.app && append_here) begin
            key_next   = req_key;
            value_next = req_value;
        end else if (ctrl.upd && match_reg) begin
            value_next = req_value;
        end else begin
            // No write for this cell: the entry is held.
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/ordered_key_value_table_core.sv =====
// Channel   Direction  Payload (tdata, lowest bit first)
// s_axis    in         cmd[2:0] key[34:3] value[66:35] position[70:67], zero fill
// m_axis    out        ok[0] full_res[1] key_out[33:2] value_out[65:34] count[70:66]
//
// An accepted request is compared against every cell in the next cycle and then acted
// on in the act state, which a stalled result can hold. A new request is taken when
// idle or in the acting cycle, never while the compare of the cell row runs, so the
// next request overlaps the act of the current one but not its compare.
// Reset (aresetn low at a clock edge) empties the table and drops any pending result.
// A stalled result register holds the act cycle, and with it the input side.
module ordered_key_value_table_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd, key, value, position from bit 0 up, zero filled to 72 bits
    input  logic [okvt_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok, full_res, key_out, value_out, count from bit 0 up, zero filled to 72 bits
    output logic [okvt_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import okvt_pkg::*;

    state_t     state_reg, state_next;
    req_t       req_reg, req_next;
    res_t       res_reg, res_next;
    logic       m_tvalid_reg, m_tvalid_next;
    count_t     count_reg, count_next;
    cell_ctrl_t ctrl;

    key_t   cell_key   [CAPACITY];
    value_t cell_value [CAPACITY];
    logic   cell_match [CAPACITY];
    logic   chain      [CAPACITY+1];

    logic   out_free;
    logic   act_go;
    logic   accept;
    logic   hit;
    value_t hit_value;
    logic   pos_ok;
    idx_t   pos_idx;

    // The row of cells: each holds one entry in insertion order. On erase every
    // cell from the match upward takes its upper neighbor's entry.
    assign chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        key_t   up_key;
        value_t up_value;
        if (g == CAPACITY - 1) begin : g_top
            assign up_key   = cell_key[g];
            assign up_value = cell_value[g];
        end else begin : g_mid
            assign up_key   = cell_key[g+1];
            assign up_value = cell_value[g+1];
        end
        okvt_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .cell_idx  (IDX_BITS'(g)),
            .count     (count_reg),
            .req_key   (req_reg.key),
            .req_value (req_reg.value),
            .up_key    (up_key),
            .up_value  (up_value),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .key       (cell_key[g]),
            .value     (cell_value[g]),
            .match     (cell_match[g])
        );
    end

    // Keys are unique, so at most one cell matches and an AND-OR picks its value.
    always_comb begin
        hit       = 1'b0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit       = hit | cell_match[i];
            hit_value = hit_value | (cell_match[i] ? cell_value[i] : '0);
        end
    end

    assign pos_idx = req_reg.position[IDX_BITS-1:0];
    assign pos_ok  = COUNT_BITS'(req_reg.position) < count_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign act_go   = (state_reg == ST_ACT) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || act_go;
    assign accept   = s_tvalid && s_tready;

    // Sequencer: compare cycle, then act cycle, which also writes the result.
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctrl          = '0;

        if (accept) begin
            req_next.cmd      = cmd_t'(s_tdata[2:0]);
            req_next.key      = KEY_BITS'(s_tdata[34:3]);
            req_next.value    = VALUE_BITS'(s_tdata[66:35]);
            req_next.position = s_tdata[70:67];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctrl.cmp   = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT: begin
                if (act_go) begin
                    res_next = '0;
                    unique case (req_reg.cmd)
                        CMD_INSERT, CMD_INSERT_UPDATE: begin
                            if (hit) begin
                                if (req_reg.cmd == CMD_INSERT_UPDATE) begin
                                    ctrl.upd    = 1'b1;
                                    res_next.ok = 1'b1;
                                end
                            end else if (count_reg == COUNT_BITS'(CAPACITY)) begin
                                res_next.full_res = 1'b1;
                            end else begin
                                ctrl.app    = 1'b1;
                                count_next  = count_reg + 1'b1;
                                res_next.ok = 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            ctrl.upd    = hit;
                            res_next.ok = hit;
                        end
                        CMD_ERASE: begin
                            if (hit) begin
                                ctrl.shift  = 1'b1;
                                count_next  = count_reg - 1'b1;
                                res_next.ok = 1'b1;
                            end
                        end
                        CMD_CONTAINS: begin
                            res_next.ok = hit;
                        end
                        CMD_GET_BY_KEY: begin
                            res_next.ok        = hit;
                            res_next.value_out = hit_value;
                        end
                        CMD_GET_BY_POS: begin
                            if (pos_ok) begin
                                res_next.ok        = 1'b1;
                                res_next.key_out   = cell_key[pos_idx];
                                res_next.value_out = cell_value[pos_idx];
                            end
                        end
                        default: begin
                        end
                    endcase
                    res_next.count = count_next;
                    m_tvalid_next  = 1'b1;
                    state_next     = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0,
                       CNT_FIELD_BITS'(res_reg.count),
                       VAL_FIELD_BITS'(res_reg.value_out),
                       KEY_FIELD_BITS'(res_reg.key_out),
                       res_reg.full_res,
                       res_reg.ok};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_count_only_in_act: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACT) |=> $stable(count_reg))
        else $error("entry count changed outside the act cycle");

    a_full_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(res_reg.ok && res_reg.full_res))
        else $error("result flags both success and full");

    a_act_follows_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |=> (state_reg == ST_ACT))
        else $error("compare cycle not followed by act cycle");
`endif

endmodule

// ===== tb/sv/ordered_key_value_table_core_tb.sv =====
`timescale 1ns / 1ps

module ordered_key_value_table_core_tb;
    import okvt_pkg::*;

    // Command code 7 has no entry in the package enum; the table treats it as a no-op.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1100;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_GUARD  = 100000;

    // One response as it appears on the result stream, held field by field.
    typedef struct packed {
        logic                      ok;
        logic                      full_res;
        logic [KEY_FIELD_BITS-1:0] key_out;
        logic [VAL_FIELD_BITS-1:0] value_out;
        logic [CNT_FIELD_BITS-1:0] count;
    } kv_result_t;

    // One line of the directed stimulus. Rows with a known answer carry it in
    // answer; the others are checked against the table mirror. A row with
    // reps above one issues that many requests with key and value stepped by one.
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        key_t                key;
        value_t              value;
        pos_t                position;
        int                  reps;
        logic                known;
        kv_result_t          answer;
    } dir_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // Mirror of the table contents, in insertion order.
    key_t   mirror_keys[CAPACITY];
    value_t mirror_values[CAPACITY];
    int     mirror_count;

    // Responses that the mirror has worked out and the table still owes.
    kv_result_t awaited_results[$];
    dir_row_t   directed_rows[$];
    key_t       key_pool[24];

    int  err_count;
    int  req_count;
    int  res_count;
    int  directed_count;
    int  peak_fill;
    int  full_rejects;
    int  drain_guard;
    bit  send_calm;
    bit  recv_calm;

    ordered_key_value_table_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one request to the mirror and returns the response the table
    // should give. A key is matched against live entries only, so slots past
    // the fill level are never looked at.
    function automatic kv_result_t apply_to_table(logic [CMD_BITS-1:0] cmd, key_t key,
                                                  value_t value, pos_t position);
        kv_result_t r;
        int         hit;
        int         i;
        r   = '0;
        hit = -1;
        for (i = 0; i < mirror_count; i++) begin
            if (hit < 0 && mirror_keys[i] == key) begin
                hit = i;
            end
        end
        case (cmd)
            CMD_INSERT, CMD_INSERT_UPDATE: begin
                if (hit >= 0) begin
                    // A present key blocks a plain insert but is overwritten
                    // by insert-or-update.
                    if (cmd == CMD_INSERT_UPDATE) begin
                        mirror_values[hit] = value;
                        r.ok = 1'b1;
                    end
                end else if (mirror_count >= CAPACITY) begin
                    r.full_res = 1'b1;
                end else begin
                    mirror_keys[mirror_count]   = key;
                    mirror_values[mirror_count] = value;
                    mirror_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_UPDATE: begin
                if (hit >= 0) begin
                    mirror_values[hit] = value;
                    r.ok = 1'b1;
                end
            end
            CMD_ERASE: begin
                // Later entries move down one place to close the gap.
                if (hit >= 0) begin
                    for (i = hit; i < mirror_count - 1; i++) begin
                        mirror_keys[i]   = mirror_keys[i + 1];
                        mirror_values[i] = mirror_values[i + 1];
                    end
                    mirror_count--;
                    r.ok = 1'b1;
                end
            end
            CMD_CONTAINS: begin
                r.ok = (hit >= 0);
            end
            CMD_GET_BY_KEY: begin
                if (hit >= 0) begin
                    r.value_out = mirror_values[hit];
                    r.ok        = 1'b1;
                end
            end
            CMD_GET_BY_POS: begin
                if (int'(position) < mirror_count) begin
                    r.key_out   = mirror_keys[position];
                    r.value_out = mirror_values[position];
                    r.ok        = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_FIELD_BITS'(mirror_count);
        return r;
    endfunction

    function automatic dir_row_t row_known(logic [CMD_BITS-1:0] cmd, key_t key, value_t value,
                                           pos_t position, logic ok, logic full_res,
                                           key_t key_out, value_t value_out,
                                           logic [CNT_FIELD_BITS-1:0] count);
        dir_row_t row;
        row.cmd      = cmd;
        row.key      = key;
        row.value    = value;
        row.position = position;
        row.reps     = 1;
        row.known    = 1'b1;
        row.answer   = '{ok, full_res, key_out, value_out, count};
        return row;
    endfunction

    function automatic dir_row_t row_mirrored(logic [CMD_BITS-1:0] cmd, key_t key,
                                              value_t value, pos_t position, int reps);
        dir_row_t row;
        row.cmd      = cmd;
        row.key      = key;
        row.value    = value;
        row.position = position;
        row.reps     = reps;
        row.known    = 1'b0;
        row.answer   = '0;
        return row;
    endfunction

    // Idle cycles before a transfer. In a calm stretch a side never idles.
    function automatic int idle_cycles(bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic void report_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Offers one request on the input stream and records the response it is
    // owed once the transfer happens. Called and left at a falling edge; the
    // valid line is written at most once per falling edge, so a back-to-back
    // request keeps it high without a dip.
    task automatic send_request(logic [CMD_BITS-1:0] cmd, key_t key, value_t value,
                                pos_t position, logic known, kv_result_t answer);
        int         gap;
        kv_result_t mirrored;
        if (req_count % 64 == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
        end
        gap = idle_cycles(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, position, value, key, cmd};
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        // The mirror always advances; a row with a known answer is checked
        // against that answer instead of the mirror's.
        mirrored = apply_to_table(cmd, key, value, position);
        awaited_results.push_back(known ? answer : mirrored);
        req_count++;
        if (mirrored.full_res) begin
            full_rejects++;
        end
        if (mirror_count > peak_fill) begin
            peak_fill = mirror_count;
        end
        @(negedge aclk);
    endtask

    // Random commands, weighted by a bias that is redrawn every 50 requests:
    // a filling stretch pushes the table to its capacity, a draining one
    // empties it, and a mixed one exercises lookups at the current level.
    function automatic logic [CMD_BITS-1:0] pick_command(int bias);
        int ins_weight;
        int era_weight;
        int r;
        ins_weight = (bias == 0) ? 55 : (bias == 1) ? 10 : 20;
        era_weight = (bias == 0) ? 5 : (bias == 1) ? 55 : 20;
        r = $urandom_range(0, 99);
        if (r < ins_weight) begin
            return CMD_INSERT;
        end
        if (r < ins_weight + era_weight) begin
            return CMD_ERASE;
        end
        r = $urandom_range(0, 19);
        if (r < 4) begin
            return CMD_INSERT_UPDATE;
        end else if (r < 7) begin
            return CMD_UPDATE;
        end else if (r < 11) begin
            return CMD_CONTAINS;
        end else if (r < 15) begin
            return CMD_GET_BY_KEY;
        end else if (r < 19) begin
            return CMD_GET_BY_POS;
        end
        return CMD_UNUSED;
    endfunction

    // Most keys hit a live entry or a small recurring pool, so that lookups,
    // duplicates and erases find something; the rest are arbitrary values.
    function automatic key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && mirror_count > 0) begin
            return mirror_keys[$urandom_range(0, mirror_count - 1)];
        end else if (r < 85) begin
            return key_pool[$urandom_range(0, 23)];
        end
        return $urandom;
    endfunction

    // Result side: each transfer is checked against the oldest awaited response.
    always @(posedge aclk) begin : result_check
        kv_result_t got;
        kv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok        = m_tdata[0];
            got.full_res  = m_tdata[1];
            got.key_out   = m_tdata[33:2];
            got.value_out = m_tdata[65:34];
            got.count     = m_tdata[70:66];
            res_count++;
            if (awaited_results.size() == 0) begin
                report_error($sformatf("unexpected result ok=%0b full=%0b key=%h val=%h cnt=%0d",
                                       got.ok, got.full_res, got.key_out, got.value_out,
                                       got.count));
            end else begin
                want = awaited_results.pop_front();
                if (got.ok !== want.ok || got.full_res !== want.full_res ||
                    got.key_out !== want.key_out || got.value_out !== want.value_out ||
                    got.count !== want.count) begin
                    report_error($sformatf(
                        "result %0d: expected ok=%0b full=%0b key=%h val=%h cnt=%0d, got ok=%0b full=%0b key=%h val=%h cnt=%0d",
                        res_count, want.ok, want.full_res, want.key_out, want.value_out,
                        want.count, got.ok, got.full_res, got.key_out, got.value_out,
                        got.count));
                end
            end
        end
    end

    // Result side back-pressure: a fresh stall length for every result, with
    // calm stretches where ready simply stays high.
    initial begin : result_accept
        int stall;
        int taken;
        m_tready = 1'b0;
        taken    = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (taken % 64 == 0) begin
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            stall = idle_cycles(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) begin
                @(posedge aclk);
            end
            taken++;
            @(negedge aclk);
        end
    end

    // Main sequence: reset, the directed rows, then the random stretch.
    initial begin : stimulus
        int i;
        int r;
        int bias;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        err_count      = 0;
        req_count      = 0;
        res_count      = 0;
        peak_fill      = 0;
        full_rejects   = 0;
        mirror_count   = 0;
        send_calm      = 1'b0;
        recv_calm      = 1'b0;
        bias           = 0;
        for (i = 0; i < CAPACITY; i++) begin
            mirror_keys[i]   = '0;
            mirror_values[i] = '0;
        end

        // The pool is larger than the capacity so the table can really fill,
        // and it holds both key extremes.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < 24; i++) begin
            key_pool[i] = $urandom;
        end

        // Directed part. Reading an empty slot, both key and value extremes,
        // duplicate insert, misses of update, erase and both gets, and the unused code come
        // first; then the table is filled to capacity to see inserts turned
        // away, and an erase at the front shows the remaining entries shifting.
        directed_rows.push_back(row_known(CMD_GET_BY_POS, '0, '0, 4'd0, 0, 0, '0, '0, 5'd0));
        directed_rows.push_back(row_known(CMD_INSERT, '0, '0, 4'd0, 1, 0, '0, '0, 5'd1));
        directed_rows.push_back(row_known(CMD_INSERT, '1, '1, 4'd15, 1, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_INSERT, '0, 32'h1234, 4'd0, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_UPDATE, 32'd1, 32'd7, 4'd0, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_ERASE, 32'd1, '0, 4'd0, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_CONTAINS, '1, '0, 4'd0, 1, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_GET_BY_KEY, '1, '0, 4'd0, 1, 0, '0, '1, 5'd2));
        directed_rows.push_back(row_known(CMD_GET_BY_KEY, 32'd5, '0, 4'd0, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_mirrored(CMD_INSERT_UPDATE, '0, 32'hA5A5A5A5, 4'd0, 1));
        directed_rows.push_back(row_known(CMD_GET_BY_POS, '0, '0, 4'd1, 1, 0, '1, '1, 5'd2));
        directed_rows.push_back(row_known(CMD_GET_BY_POS, '0, '0, 4'd15, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_known(CMD_UNUSED, '1, '1, 4'd15, 0, 0, '0, '0, 5'd2));
        directed_rows.push_back(row_mirrored(CMD_INSERT, 32'h100, 32'h5A000000, 4'd0,
                                             CAPACITY - 2));
        directed_rows.push_back(row_known(CMD_INSERT, 32'h12345678, 32'd9, 4'd0,
                                          0, 1, '0, '0, 5'd16));
        directed_rows.push_back(row_known(CMD_INSERT_UPDATE, 32'h87654321, 32'd9, 4'd0,
                                          0, 1, '0, '0, 5'd16));
        directed_rows.push_back(row_mirrored(CMD_INSERT_UPDATE, '1, 32'h0F0F0F0F, 4'd0, 1));
        directed_rows.push_back(row_mirrored(CMD_ERASE, '0, '0, 4'd0, 1));
        directed_rows.push_back(row_mirrored(CMD_GET_BY_POS, '0, '0, 4'd0, 1));
        directed_rows.push_back(row_mirrored(CMD_GET_BY_POS, '0, '0, 4'd15, 1));
        directed_rows.push_back(row_mirrored(CMD_UPDATE, 32'h105, '0, 4'd0, 1));
        directed_rows.push_back(row_mirrored(CMD_ERASE, 32'h10D, '0, 4'd0, 1));

        // Reset is held low from the start and released at a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[n]) begin
            for (r = 0; r < directed_rows[n].reps; r++) begin
                send_request(directed_rows[n].cmd, directed_rows[n].key + key_t'(r),
                             directed_rows[n].value + value_t'(r), directed_rows[n].position,
                             directed_rows[n].known, directed_rows[n].answer);
            end
        end
        directed_count = req_count;

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                bias = $urandom_range(0, 2);
            end
            send_request(pick_command(bias), pick_key(), $urandom,
                         pos_t'($urandom_range(0, 15)), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Let the owed responses come in, then wait out a settle period so the
        // table can show any response it should not produce.
        drain_guard = 0;
        while (awaited_results.size() != 0 && drain_guard < DRAIN_GUARD) begin
            @(posedge aclk);
            drain_guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            report_error($sformatf("%0d responses never arrived", awaited_results.size()));
            err_count += awaited_results.size() - 1;
        end

        $display("Sent %0d requests (%0d directed) covering all eight command codes, checked %0d responses.",
                 req_count, directed_count, res_count);
        $display("Table fill peaked at %0d of %0d entries; %0d inserts turned away as full; %0d errors.",
                 peak_fill, CAPACITY, full_rejects, err_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("Timed out waiting on the table core.");
        $display("FAILURE");
        $finish;
    end

endmodule
